[src/cda_pkg.sv]
// Shared types, constants and calendar functions for the calendar date advance block.
`default_nettype none

package cda_pkg;

    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned OFS_W   = 16;
    localparam int unsigned SUM_W   = 17;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned CYC_W   = 9;
    localparam int unsigned QUO_W   = 8;
    localparam int unsigned PROD_W  = 23;

    localparam int unsigned DIV25_MUL   = 1311;
    localparam int unsigned DIV25_SHIFT = 15;
    localparam int unsigned LEAP_CYCLE  = 400;
    localparam int unsigned CENTURY     = 100;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_MID   = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_LONG  = 5'd31;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [OFS_W-1:0]   offset_days;
    } t_req;

    typedef struct packed {
        logic               leap_flag;
        logic [DAY_W-1:0]   month_length;
        logic [DOY_W-1:0]   day_of_year;
        logic [DAY_W-1:0]   new_day;
        logic [MONTH_W-1:0] new_month;
        logic [YEAR_W-1:0]  new_year;
    } t_res;

    typedef struct packed {
        logic ready;
        logic done;
    } t_core_stat;

    // Gregorian leap test from the two low year bits and the year modulo 400.
    function automatic logic f_is_leap(input logic [1:0] y_lo, input logic [CYC_W-1:0] r400);
        logic century;
        century = (r400 == CYC_W'(CENTURY)) || (r400 == CYC_W'(2 * CENTURY))
               || (r400 == CYC_W'(3 * CENTURY));
        return (y_lo == 2'b00) && !century;
    endfunction

    function automatic logic [DAY_W-1:0] f_month_days(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_FEB: len = DAYS_SHORT + DAY_W'(leap);
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_MID;
            default: len = DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[src/cda_core.sv]
// Sequencer and shared subtract and compare datapath that advance a date month by month.
`default_nettype none

module cda_core
    import cda_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  t_req        i_req,
    input  wire         i_take,
    output t_core_stat  o_stat,
    output t_res        o_res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_REM,
        ST_DOY,
        ST_ADV,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic [YEAR_W-1:0]   r_ny, n_ny;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [MONTH_W-1:0]  r_nm, n_nm;
    logic [MONTH_W-1:0]  r_cnt, n_cnt;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [CYC_W-1:0]    r_r400, n_r400;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [DOY_W-1:0]    r_doy, n_doy;
    logic [DAY_W-1:0]    r_mlen, n_mlen;
    logic                r_leap, n_leap;

    logic [PROD_W-1:0]   w_prod;
    logic [YEAR_W-1:0]   w_rem;
    logic                w_cur_leap;
    logic [DAY_W-1:0]    w_len;
    logic [DAY_W-1:0]    w_doy_len;

    // The year divided by 16 and then by 25 through a reciprocal gives the year over 400.
    assign w_prod     = PROD_W'(r_year[YEAR_W-1:4]) * PROD_W'(DIV25_MUL);
    assign w_rem      = r_year - YEAR_W'(r_quo) * YEAR_W'(LEAP_CYCLE);
    assign w_cur_leap = f_is_leap(r_ny[1:0], r_r400);
    assign w_len      = f_month_days(r_nm, w_cur_leap);
    assign w_doy_len  = f_month_days(r_cnt, r_leap);

    always_comb begin
        n_state = r_state;
        n_quo   = r_quo;
        n_year  = r_year;
        n_ny    = r_ny;
        n_month = r_month;
        n_nm    = r_nm;
        n_cnt   = r_cnt;
        n_day   = r_day;
        n_r400  = r_r400;
        n_sum   = r_sum;
        n_doy   = r_doy;
        n_mlen  = r_mlen;
        n_leap  = r_leap;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_year = i_req.year;
                    n_ny   = i_req.year;
                    if (i_req.month == '0) begin
                        n_month = MONTH_JAN;
                    end else if (i_req.month > MONTH_DEC) begin
                        n_month = MONTH_DEC;
                    end else begin
                        n_month = i_req.month;
                    end
                    n_nm  = n_month;
                    n_day = (i_req.day == '0) ? DAY_W'(1) : i_req.day;
                    n_sum = SUM_W'(n_day) + SUM_W'(i_req.offset_days);
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                n_quo   = w_prod[PROD_W-1:DIV25_SHIFT];
                n_state = ST_REM;
            end
            ST_REM: begin
                n_r400  = w_rem[CYC_W-1:0];
                n_leap  = f_is_leap(r_year[1:0], n_r400);
                n_cnt   = MONTH_JAN;
                n_doy   = '0;
                n_state = ST_DOY;
            end
            ST_DOY: begin
                if (r_cnt == r_month) begin
                    n_doy   = r_doy + DOY_W'(r_day);
                    n_mlen  = w_doy_len;
                    n_state = ST_ADV;
                end else begin
                    n_doy = r_doy + DOY_W'(w_doy_len);
                    n_cnt = r_cnt + MONTH_W'(1);
                end
            end
            ST_ADV: begin
                if (r_sum > SUM_W'(w_len)) begin
                    n_sum = r_sum - SUM_W'(w_len);
                    if (r_nm == MONTH_DEC) begin
                        n_nm = MONTH_JAN;
                        n_ny = r_ny + YEAR_W'(1);
                        if ((r_ny == {YEAR_W{1'b1}}) || (r_r400 == CYC_W'(LEAP_CYCLE - 1))) begin
                            n_r400 = '0;
                        end else begin
                            n_r400 = r_r400 + CYC_W'(1);
                        end
                    end else begin
                        n_nm = r_nm + MONTH_W'(1);
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_quo   <= n_quo;
        r_year  <= n_year;
        r_ny    <= n_ny;
        r_month <= n_month;
        r_nm    <= n_nm;
        r_cnt   <= n_cnt;
        r_day   <= n_day;
        r_r400  <= n_r400;
        r_sum   <= n_sum;
        r_doy   <= n_doy;
        r_mlen  <= n_mlen;
        r_leap  <= n_leap;
    end

    assign o_stat.ready = (r_state == ST_IDLE);
    assign o_stat.done  = (r_state == ST_DONE);

    assign o_res.new_year     = r_ny;
    assign o_res.new_month    = r_nm;
    assign o_res.new_day      = r_sum[DAY_W-1:0];
    assign o_res.day_of_year  = r_doy;
    assign o_res.month_length = r_mlen;
    assign o_res.leap_flag    = r_leap;

endmodule

`default_nettype wire

[src/calendar_date_advance.sv]
// Top level of the calendar date advance block with stream ports and output register.
// Steps: the year is reduced modulo 400, the day of year is summed month by month, and then
// the date is advanced month by month over the offset before the result is registered.
// One transaction at a time: a new one is accepted only once the core is idle again.
// The result register frees the core, so a new transaction is taken while a result waits.
// Reset is synchronous and active low; it clears the sequencer and the output valid flag.
`default_nettype none

module calendar_date_advance
    import cda_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: year, month, day, offset_days, zero fill.
    input  wire  [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // Fields from bit 0: new_year, new_month, new_day, day_of_year, month_length, leap_flag.
    output logic [39:0] o_m_axis_tdata
);

    t_req        w_req;
    t_res        w_res;
    t_core_stat  w_stat;
    logic        w_start;
    logic        w_take;
    logic        r_valid;
    t_res        r_data;

    assign w_req.year        = i_s_axis_tdata[15:0];
    assign w_req.month       = i_s_axis_tdata[19:16];
    assign w_req.day         = i_s_axis_tdata[24:20];
    assign w_req.offset_days = i_s_axis_tdata[40:25];

    assign o_s_axis_tready = w_stat.ready;
    assign w_start = i_s_axis_tvalid && w_stat.ready;
    assign w_take  = w_stat.done && (!r_valid || i_m_axis_tready);

    cda_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .i_take  (w_take),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (w_take) begin
            r_data <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("core still ready after taking a transaction");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[19:16] != 4'd0)
                          && (o_m_axis_tdata[19:16] <= MONTH_DEC)
                          && (o_m_axis_tdata[24:20] != 5'd0)))
        else $error("result month or day out of range");

    a_mlen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[38:34] >= DAYS_SHORT))
        else $error("result month length below 28");

    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_m_axis_tvalid)
        else $error("finished result not presented");

endmodule

`default_nettype wire

[tb/calendar_date_advance_tb.sv]
// Self-checking testbench for the calendar date advance block with a built-in date predictor.

module calendar_date_advance_tb;
    import cda_pkg::*;

    localparam int unsigned STALL_LIMIT = 12000;
    localparam int unsigned DRAIN_CYCLES = 2300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // Fields from bit 0: year, month, day, offset_days, zero fill.
    logic [47:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // Fields from bit 0: new_year, new_month, new_day, day_of_year, month_length, leap_flag.
    logic [39:0] o_m_axis_tdata;

    t_res        expected_dates[$];
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned stall_left;
    logic        idling_on;

    calendar_date_advance dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        if (y[1:0] != 2'b00) return 1'b0;
        if ((y % 100) != 0) return 1'b1;
        return ((y % 400) == 0);
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [YEAR_W-1:0] y,
                                                       input logic [MONTH_W-1:0] m);
        if (m == MONTH_FEB) return leap_year(y) ? 5'd29 : DAYS_SHORT;
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            return DAYS_MID;
        return DAYS_LONG;
    endfunction

    function automatic t_res advance_date(input logic [47:0] req);
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        logic [SUM_W-1:0]   remaining;
        logic [DOY_W-1:0]   ordinal;
        logic [DAY_W-1:0]   span;
        t_res               res;
        y = req[15:0];
        m = req[19:16];
        d = req[24:20];
        if (m == 4'd0) m = MONTH_JAN;
        if (m > MONTH_DEC) m = MONTH_DEC;
        if (d == 5'd0) d = 5'd1;
        ordinal = DOY_W'(d);
        for (int unsigned k = 1; k < m; k++)
            ordinal = ordinal + DOY_W'(days_in_month(y, MONTH_W'(k)));
        res.day_of_year  = ordinal;
        res.month_length = days_in_month(y, m);
        res.leap_flag    = leap_year(y);
        remaining = SUM_W'(d) + SUM_W'(req[40:25]);
        span = res.month_length;
        while (remaining > SUM_W'(span)) begin
            remaining = remaining - SUM_W'(span);
            m = m + 4'd1;
            if (m > MONTH_DEC) begin
                m = MONTH_JAN;
                y = y + 16'd1;
            end
            span = days_in_month(y, m);
        end
        res.new_year  = y;
        res.new_month = m;
        res.new_day   = remaining[DAY_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Transaction bookkeeping and result comparison, both on the rising edge.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            expected_dates.push_back(advance_date(i_s_axis_tdata));
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_dates.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata[15:0], 0);
            end else begin
                want = expected_dates.pop_front();
                if (o_m_axis_tdata[15:0] != want.new_year)
                    report_mismatch("new_year", o_m_axis_tdata[15:0], want.new_year);
                if (o_m_axis_tdata[19:16] != want.new_month)
                    report_mismatch("new_month", o_m_axis_tdata[19:16], want.new_month);
                if (o_m_axis_tdata[24:20] != want.new_day)
                    report_mismatch("new_day", o_m_axis_tdata[24:20], want.new_day);
                if (o_m_axis_tdata[33:25] != want.day_of_year)
                    report_mismatch("day_of_year", o_m_axis_tdata[33:25], want.day_of_year);
                if (o_m_axis_tdata[38:34] != want.month_length)
                    report_mismatch("month_length", o_m_axis_tdata[38:34],
                                    want.month_length);
                if (o_m_axis_tdata[39] != want.leap_flag)
                    report_mismatch("leap_flag", o_m_axis_tdata[39], want.leap_flag);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** calendar_date_advance: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 16) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_date(input logic [15:0] y, input logic [3:0] m, input logic [4:0] d,
                             input logic [15:0] ofs);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, ofs, d, m, y};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [3:0] pick_month();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
        return 4'($urandom_range(1, 12));
    endfunction

    function automatic logic [4:0] pick_day(input logic [15:0] y, input logic [3:0] m);
        logic [3:0] mm;
        mm = (m == 4'd0) ? MONTH_JAN : (m > MONTH_DEC) ? MONTH_DEC : m;
        if ($urandom_range(0, 7) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(1, days_in_month(y, mm)));
    endfunction

    function automatic logic [15:0] pick_year();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(65520, 65535));
            2: return 16'(400 * $urandom_range(0, 163) + $urandom_range(0, 8) - 4);
            default: return 16'($urandom_range(1890, 2110));
        endcase
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1, 2: return 16'($urandom_range(0, 4000));
            default: return 16'($urandom_range(0, 400));
        endcase
    endfunction

    task automatic test_boundary_dates();
        send_date(16'd2024, 4'd1, 5'd1, 16'd0);
        send_date(16'd2023, 4'd12, 5'd31, 16'd1);
        send_date(16'd65535, 4'd12, 5'd31, 16'd1);
        send_date(16'd65535, 4'd12, 5'd1, 16'd65535);
        send_date(16'd0, 4'd1, 5'd1, 16'd65535);
        send_date(16'd2024, 4'd12, 5'd31, 16'd0);
        send_date(16'd2023, 4'd12, 5'd31, 16'd365);
        send_date(16'd2024, 4'd0, 5'd15, 16'd10);
        send_date(16'd2024, 4'd13, 5'd5, 16'd40);
        send_date(16'd2024, 4'd15, 5'd31, 16'd0);
        send_date(16'd2024, 4'd6, 5'd0, 16'd0);
        send_date(16'd2023, 4'd4, 5'd31, 16'd0);
        send_date(16'd2024, 4'd2, 5'd31, 16'd0);
        send_date(16'd2023, 4'd2, 5'd30, 16'd5);
        send_date(16'd1999, 4'd11, 5'd30, 16'd32);
    endtask

    task automatic test_leap_years();
        logic [15:0] years[10];
        years = '{16'd1900, 16'd2000, 16'd2100, 16'd2400, 16'd1996,
                  16'd1999, 16'd0, 16'd100, 16'd65532, 16'd65500};
        foreach (years[k]) begin
            send_date(years[k], 4'd2, 5'd28, 16'd1);
            send_date(years[k], 4'd3, 5'd1, 16'd0);
        end
    endtask

    task automatic test_random_dates(input int unsigned count);
        logic [15:0] y;
        logic [3:0]  m;
        repeat (count) begin
            y = pick_year();
            m = pick_month();
            send_date(y, m, pick_day(y, m), pick_offset());
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        idling_on       = 1'b1;
        stall_left      = 0;
        quiet_cycles    = 0;
        mismatch_count  = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_boundary_dates();
        test_leap_years();
        test_random_dates(175);
        idling_on = 1'b0;
        test_random_dates(60);
        i_s_axis_tvalid <= 1'b0;

        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_dates.size() != 0)
            report_mismatch("results still missing", 0, expected_dates.size());

        if (mismatch_count == 0) begin
            $display("** calendar_date_advance: PASSED **");
        end else begin
            $display("** calendar_date_advance: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
src/cda_pkg.sv
src/cda_core.sv
src/calendar_date_advance.sv
tb/calendar_date_advance_tb.sv
